### design/f16rgb_pkg.sv
// ----------------------------------------------------------------------------
// f16rgb_pkg
// Shared types, constants and the half-precision to byte conversion for the
// planar half-precision to interleaved RGB8 packer.
// ----------------------------------------------------------------------------
`default_nettype none

package f16rgb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_DIM_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W  = 16;
  localparam int BYTE_W    = 8;
  localparam int CHAN_W    = 2;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 11'd1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef enum logic [CHAN_W-1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              frame_last;
  } pixel_t;

  // Maps a half sample from [-1,1] to 0..255, rounding half up, exactly.
  // For normal values below one in magnitude, 255*|v|/2 = prod / 2^sh.
  function automatic logic [BYTE_W-1:0] half_to_byte(input logic [SAMPLE_W-1:0] h);
    logic              neg;
    logic [4:0]        ex;
    logic [9:0]        fr;
    logic [18:0]       prod;
    logic [4:0]        sh;
    logic [18:0]       q;
    logic [18:0]       mask;
    logic              inexact;
    logic [BYTE_W-1:0] res;
    neg     = h[15];
    ex      = h[14:10];
    fr      = h[9:0];
    prod    = (19'({1'b1, fr}) << 8) - 19'({1'b1, fr});
    sh      = 5'd26 - ex;
    q       = prod >> sh;
    mask    = ~(19'h7ffff << sh);
    inexact = |(prod & mask);
    if (ex == 5'd0) begin
      res = 8'd128;
    end else if (ex == 5'd31) begin
      res = ((fr != 10'd0) || neg) ? 8'd0 : 8'd255;
    end else if (ex >= 5'd15) begin
      res = neg ? 8'd0 : 8'd255;
    end else if (neg) begin
      res = 8'd128 - q[7:0] - {7'd0, inexact};
    end else begin
      res = 8'd128 + q[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/f16rgb_front.sv
// ----------------------------------------------------------------------------
// f16rgb_front
// Accepts samples, converts them to bytes, tracks plane and pixel position,
// keeps red and green bytes in the plane stores and hands complete pixels
// to the queue when a blue sample arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module f16rgb_front #(
  parameter int MAX_WIDTH  = f16rgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = f16rgb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [f16rgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [f16rgb_pkg::CFG_DIM_W-1:0]    cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [f16rgb_pkg::SAMPLE_W-1:0]     in_half_sample,
  input  wire logic [f16rgb_pkg::QCNT_W-1:0]       q_count,
  output logic                                     push_valid,
  output f16rgb_pkg::pixel_t                       push_data
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [f16rgb_pkg::CFG_DIM_W-1:0] width_r, width_nxt;
  logic [f16rgb_pkg::CFG_DIM_W-1:0] height_r, height_nxt;
  logic [XW-1:0]                    col_r, col_nxt;
  logic [YW-1:0]                    row_r, row_nxt;
  logic [AW-1:0]                    addr_r, addr_nxt;
  f16rgb_pkg::chan_t                plane_r, plane_nxt;

  logic                             s1_valid_r;
  logic [f16rgb_pkg::BYTE_W-1:0]    s1_blue_r;
  logic                             s1_last_r;
  logic [f16rgb_pkg::BYTE_W-1:0]    red_rd_r;
  logic [f16rgb_pkg::BYTE_W-1:0]    green_rd_r;

  logic [f16rgb_pkg::BYTE_W-1:0]    red_mem   [STORE_DEPTH];
  logic [f16rgb_pkg::BYTE_W-1:0]    green_mem [STORE_DEPTH];

  logic [31:0]                      width_last32;
  logic [31:0]                      height_last32;
  logic                             col_last;
  logic                             row_last;
  logic                             plane_end;
  logic                             accept;
  logic                             cfg_hit;
  logic [f16rgb_pkg::BYTE_W-1:0]    sample_byte;
  logic [f16rgb_pkg::QCNT_W-1:0]    used;

  always_comb begin
    if (width_r == '0) begin
      width_last32 = 32'd0;
    end else if ({21'd0, width_r} > 32'(MAX_WIDTH)) begin
      width_last32 = 32'(MAX_WIDTH - 1);
    end else begin
      width_last32 = {21'd0, width_r} - 32'd1;
    end
    if (height_r == '0) begin
      height_last32 = 32'd0;
    end else if ({21'd0, height_r} > 32'(MAX_HEIGHT)) begin
      height_last32 = 32'(MAX_HEIGHT - 1);
    end else begin
      height_last32 = {21'd0, height_r} - 32'd1;
    end
  end

  assign col_last    = (col_r == width_last32[XW-1:0]);
  assign row_last    = (row_r == height_last32[YW-1:0]);
  assign plane_end   = col_last && row_last;
  assign sample_byte = f16rgb_pkg::half_to_byte(in_half_sample);
  assign used        = q_count + {{(f16rgb_pkg::QCNT_W-1){1'b0}}, s1_valid_r};
  assign in_ready    = (plane_r != f16rgb_pkg::CH_BLUE) ||
                       (used < f16rgb_pkg::QCNT_W'(f16rgb_pkg::QUEUE_DEPTH));
  assign accept      = in_valid && in_ready;
  assign cfg_hit     = cfg_wr_en && ((cfg_index == f16rgb_pkg::REG_IMAGE_WIDTH) ||
                                     (cfg_index == f16rgb_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    addr_nxt   = addr_r;
    plane_nxt  = plane_r;
    if (cfg_hit) begin
      if (cfg_index == f16rgb_pkg::REG_IMAGE_WIDTH) begin
        width_nxt = cfg_wr_data;
      end else begin
        height_nxt = cfg_wr_data;
      end
      col_nxt   = '0;
      row_nxt   = '0;
      addr_nxt  = '0;
      plane_nxt = f16rgb_pkg::CH_RED;
    end else if (accept) begin
      if (plane_end) begin
        col_nxt  = '0;
        row_nxt  = '0;
        addr_nxt = '0;
        case (plane_r)
          f16rgb_pkg::CH_RED:   plane_nxt = f16rgb_pkg::CH_GREEN;
          f16rgb_pkg::CH_GREEN: plane_nxt = f16rgb_pkg::CH_BLUE;
          default:              plane_nxt = f16rgb_pkg::CH_RED;
        endcase
      end else begin
        addr_nxt = addr_r + AW'(1);
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_r + YW'(1);
        end else begin
          col_nxt = col_r + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= f16rgb_pkg::DIM_RESET;
      height_r   <= f16rgb_pkg::DIM_RESET;
      col_r      <= '0;
      row_r      <= '0;
      addr_r     <= '0;
      plane_r    <= f16rgb_pkg::CH_RED;
      s1_valid_r <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      addr_r     <= addr_nxt;
      plane_r    <= plane_nxt;
      s1_valid_r <= accept && (plane_r == f16rgb_pkg::CH_BLUE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (plane_r == f16rgb_pkg::CH_BLUE)) begin
      s1_blue_r <= sample_byte;
      s1_last_r <= plane_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (plane_r == f16rgb_pkg::CH_RED)) begin
      red_mem[addr_r] <= sample_byte;
    end
    if (accept && (plane_r == f16rgb_pkg::CH_BLUE)) begin
      red_rd_r <= red_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (plane_r == f16rgb_pkg::CH_GREEN)) begin
      green_mem[addr_r] <= sample_byte;
    end
    if (accept && (plane_r == f16rgb_pkg::CH_BLUE)) begin
      green_rd_r <= green_mem[addr_r];
    end
  end

  assign push_valid           = s1_valid_r;
  assign push_data.red        = red_rd_r;
  assign push_data.green      = green_rd_r;
  assign push_data.blue       = s1_blue_r;
  assign push_data.frame_last = s1_last_r;

endmodule

`default_nettype wire

### design/f16rgb_queue.sv
// ----------------------------------------------------------------------------
// f16rgb_queue
// Short first-in first-out queue of complete pixels between the front and
// the back end. The front never pushes into a full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module f16rgb_queue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push_valid,
  input  wire f16rgb_pkg::pixel_t             push_data,
  input  wire logic                           pop,
  output f16rgb_pkg::pixel_t                  head,
  output logic                                not_empty,
  output logic [f16rgb_pkg::QCNT_W-1:0]       count
);

  f16rgb_pkg::pixel_t                  mem_r [f16rgb_pkg::QUEUE_DEPTH];
  logic [f16rgb_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [f16rgb_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [f16rgb_pkg::QCNT_W-1:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push_valid ? wr_ptr_r + f16rgb_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + f16rgb_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + f16rgb_pkg::QCNT_W'(1);
    end else if (pop && !push_valid) begin
      count_nxt = count_r - f16rgb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

`default_nettype wire

### design/f16rgb_back.sv
// ----------------------------------------------------------------------------
// f16rgb_back
// Serializes each queued pixel into its red, green and blue bytes through a
// registered output stage, one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module f16rgb_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire f16rgb_pkg::pixel_t            head,
  input  wire logic                          not_empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [f16rgb_pkg::BYTE_W-1:0]      out_pixel_byte,
  output logic [f16rgb_pkg::CHAN_W-1:0]      out_channel_index,
  output logic                               out_pixel_last,
  output logic                               out_frame_last
);

  f16rgb_pkg::chan_t               chan_r, chan_nxt;
  logic                            valid_r, valid_nxt;
  logic [f16rgb_pkg::BYTE_W-1:0]   byte_r;
  f16rgb_pkg::chan_t               chan_out_r;
  logic                            pixel_last_r;
  logic                            frame_last_r;
  logic                            advance;
  logic                            load;
  logic [f16rgb_pkg::BYTE_W-1:0]   sel_byte;

  assign advance = !valid_r || out_ready;
  assign load    = advance && not_empty;
  assign pop     = load && (chan_r == f16rgb_pkg::CH_BLUE);

  always_comb begin
    case (chan_r)
      f16rgb_pkg::CH_RED:   sel_byte = head.red;
      f16rgb_pkg::CH_GREEN: sel_byte = head.green;
      default:              sel_byte = head.blue;
    endcase
  end

  always_comb begin
    chan_nxt  = chan_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = not_empty;
    end
    if (load) begin
      case (chan_r)
        f16rgb_pkg::CH_RED:   chan_nxt = f16rgb_pkg::CH_GREEN;
        f16rgb_pkg::CH_GREEN: chan_nxt = f16rgb_pkg::CH_BLUE;
        default:              chan_nxt = f16rgb_pkg::CH_RED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= f16rgb_pkg::CH_RED;
      valid_r <= 1'b0;
    end else begin
      chan_r  <= chan_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r       <= sel_byte;
      chan_out_r   <= chan_r;
      pixel_last_r <= (chan_r == f16rgb_pkg::CH_BLUE);
      frame_last_r <= (chan_r == f16rgb_pkg::CH_BLUE) && head.frame_last;
    end
  end

  assign out_valid         = valid_r;
  assign out_pixel_byte    = byte_r;
  assign out_channel_index = chan_out_r;
  assign out_pixel_last    = pixel_last_r;
  assign out_frame_last    = frame_last_r;

endmodule

`default_nettype wire

### design/fp16_planar_to_rgb8_packer.sv
// Red and green samples are taken one per cycle and produce no output.
// A blue sample's red, green and blue bytes pass the front's pixel register,
// the queue and the output register and leave one byte per cycle while
// out_ready is high; a 4-pixel queue absorbs bursts of blue samples.
// Reset clears position counters, sets both dimensions to 1024 and leaves the
// plane stores uninitialized; no clearing pass is run.
// ----------------------------------------------------------------------------
// fp16_planar_to_rgb8_packer
// Converts planar half-precision RGB samples into an interleaved stream of
// 8-bit channel bytes with pixel and frame end marks.
// ----------------------------------------------------------------------------
`default_nettype none

module fp16_planar_to_rgb8_packer #(
  parameter int MAX_WIDTH  = f16rgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = f16rgb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [f16rgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [f16rgb_pkg::CFG_DIM_W-1:0]   cfg_wr_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [f16rgb_pkg::SAMPLE_W-1:0]    in_half_sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [f16rgb_pkg::BYTE_W-1:0]           out_pixel_byte,
  output logic [f16rgb_pkg::CHAN_W-1:0]           out_channel_index,
  output logic                                    out_pixel_last,
  output logic                                    out_frame_last
);

  logic                            push_valid;
  f16rgb_pkg::pixel_t              push_data;
  logic                            pop;
  f16rgb_pkg::pixel_t              head;
  logic                            not_empty;
  logic [f16rgb_pkg::QCNT_W-1:0]   q_count;

  f16rgb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_half_sample (in_half_sample),
    .q_count        (q_count),
    .push_valid     (push_valid),
    .push_data      (push_data)
  );

  f16rgb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .count      (q_count)
  );

  f16rgb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .not_empty         (not_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_byte    (out_pixel_byte),
    .out_channel_index (out_channel_index),
    .out_pixel_last    (out_pixel_last),
    .out_frame_last    (out_frame_last)
  );

endmodule

`default_nettype wire
